/* sv/dqz_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and a helper function for the int8 to float dequantizer.
// No dependencies.
package dqz_pkg;

   localparam int SAMPLE_W   = 8;
   localparam int VALUE_W    = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int DIFF_W     = 10;
   localparam int BEXP_W     = 10;
   localparam int LZ_W       = 5;

   localparam logic [VALUE_W-1:0] QNAN_DEFAULT = 32'h7FC0_0000;
   localparam logic [VALUE_W-1:0] SCALE_RESET  = 32'h3F80_0000;
   localparam logic [VALUE_W-1:0] QUIET_BIT    = 32'h0040_0000;
   localparam logic [7:0]         EXP_MAX      = 8'hFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SIGNED_MODE = 2'd0,
      CSR_ZERO_POINT  = 2'd1,
      CSR_SCALE_BITS  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                signed_mode;
      logic [SAMPLE_W-1:0] zero_point;
      logic [VALUE_W-1:0]  scale_bits;
   } cfg_type;

   // leading zero count of a nonzero 32-bit word
   function automatic logic [LZ_W-1:0] lzc32(input logic [VALUE_W-1:0] x);
      logic [LZ_W-1:0] n;
      n = '0;
      for (int i = 0; i < VALUE_W; i++) begin
         if (x[i]) begin
            n = LZ_W'(VALUE_W - 1 - i);
         end
      end
      return n;
   endfunction

endpackage

/* sv/dqz_channels.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response transfers.
// Depends on dqz_pkg.
interface dqz_req_if
   import dqz_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;
   logic                last_in;

   modport source (output valid, sample, last_in, input ready);
   modport sink   (input valid, sample, last_in, output ready);
endinterface

interface dqz_rsp_if
   import dqz_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value_bits;
   logic               last_out;

   modport source (output valid, value_bits, last_out, input ready);
   modport sink   (input valid, value_bits, last_out, output ready);
endinterface

/* sv/dqz_pipe.sv */
`timescale 1ns / 1ps
// Five-stage dequantize datapath: decode, multiply, normalize count, shift, round.
// Depends on dqz_pkg.
module dqz_pipe
   import dqz_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [SAMPLE_W-1:0] in_sample,
   input  logic                in_last,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [VALUE_W-1:0]  out_value,
   output logic                out_last
);

   typedef struct packed {
      logic               last;
      logic               special;
      logic [VALUE_W-1:0] spec_value;
      logic               sign;
      logic [7:0]         exp;
   } ctl_type;

   typedef struct packed {
      ctl_type    ctl;
      logic [7:0] mag;
      logic [23:0] sig;
   } s1_type;

   typedef struct packed {
      ctl_type            ctl;
      logic [VALUE_W-1:0] prod;
   } s2_type;

   typedef struct packed {
      ctl_type            ctl;
      logic [VALUE_W-1:0] prod;
      logic [LZ_W-1:0]    lz;
      logic [BEXP_W-1:0]  bexp;
   } s3_type;

   typedef struct packed {
      ctl_type            ctl;
      logic [VALUE_W-1:0] norm;
      logic               subn;
      logic [22:0]        sub_mant;
      logic [BEXP_W-1:0]  bexp;
   } s4_type;

   logic [5:1] v_ff;
   logic [5:1] ld;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   logic               last_ff;

   // stall chain: a stage loads when empty or when the stage after it loads
   assign ld[5]    = !v_ff[5] || out_ready;
   assign ld[4]    = !v_ff[4] || ld[5];
   assign ld[3]    = !v_ff[3] || ld[4];
   assign ld[2]    = !v_ff[2] || ld[3];
   assign ld[1]    = !v_ff[1] || ld[2];
   assign in_ready = ld[1];

   // stage 1: difference and scale decode
   always_comb begin
      logic signed [DIFF_W-1:0] a, b, d;
      logic [DIFF_W-1:0]        mag_w;
      logic [7:0]               e;
      logic [22:0]              f;
      logic                     rs;
      a = $signed({{(DIFF_W-SAMPLE_W){cfg.signed_mode & in_sample[SAMPLE_W-1]}}, in_sample});
      b = $signed({{(DIFF_W-SAMPLE_W){cfg.signed_mode & cfg.zero_point[SAMPLE_W-1]}},
                   cfg.zero_point});
      d = a - b;
      mag_w = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
      e  = cfg.scale_bits[30:23];
      f  = cfg.scale_bits[22:0];
      rs = d[DIFF_W-1] ^ cfg.scale_bits[31];
      s1_in.ctl.last       = in_last;
      s1_in.ctl.sign       = rs;
      s1_in.mag            = mag_w[7:0];
      s1_in.ctl.exp        = (e == 8'd0) ? 8'd1 : e;
      s1_in.sig            = {(e != 8'd0), f};
      s1_in.ctl.special    = 1'b1;
      if (e == EXP_MAX) begin
         if (f != 23'd0) begin
            s1_in.ctl.spec_value = cfg.scale_bits | QUIET_BIT;
         end else if (mag_w == '0) begin
            s1_in.ctl.spec_value = QNAN_DEFAULT;
         end else begin
            s1_in.ctl.spec_value = {rs, EXP_MAX, 23'd0};
         end
      end else if (mag_w == '0 || (e == 8'd0 && f == 23'd0)) begin
         s1_in.ctl.spec_value = {rs, 31'd0};
      end else begin
         s1_in.ctl.special    = 1'b0;
         s1_in.ctl.spec_value = '0;
      end
   end

   // stage 2: 8 x 24 product
   always_comb begin
      s2_in.ctl  = s1_ff.ctl;
      s2_in.prod = VALUE_W'({24'd0, s1_ff.mag} * {8'd0, s1_ff.sig});
   end

   // stage 3: leading zeros and biased exponent
   always_comb begin
      s3_in.ctl  = s2_ff.ctl;
      s3_in.prod = s2_ff.prod;
      s3_in.lz   = lzc32(s2_ff.prod);
      s3_in.bexp = BEXP_W'({2'b00, s2_ff.ctl.exp} + BEXP_W'(8)
                           - {{(BEXP_W-LZ_W){1'b0}}, s3_in.lz});
   end

   // stage 4: normalize, or align a subnormal result
   always_comb begin
      logic [LZ_W-1:0]    sub_sh;
      logic [VALUE_W-1:0] sub_w;
      sub_sh = LZ_W'(s3_ff.ctl.exp - 8'd1);
      sub_w  = s3_ff.prod << sub_sh;
      s4_in.ctl      = s3_ff.ctl;
      s4_in.norm     = s3_ff.prod << s3_ff.lz;
      s4_in.subn     = $signed(s3_ff.bexp) < $signed(BEXP_W'(1));
      s4_in.sub_mant = sub_w[22:0];
      s4_in.bexp     = s3_ff.bexp;
   end

   // stage 5: round to nearest even and pack
   always_comb begin
      logic              rup;
      logic [24:0]       sum;
      logic [BEXP_W-1:0] exp_f;
      rup   = s4_ff.norm[7] & (s4_ff.norm[8] | (|s4_ff.norm[6:0]));
      sum   = {1'b0, s4_ff.norm[31:8]} + {24'd0, rup};
      exp_f = s4_ff.bexp + {{(BEXP_W-1){1'b0}}, sum[24]};
      if (s4_ff.ctl.special) begin
         val_in = s4_ff.ctl.spec_value;
      end else if (s4_ff.subn) begin
         val_in = {s4_ff.ctl.sign, 8'd0, s4_ff.sub_mant};
      end else if ($signed(exp_f) >= $signed(BEXP_W'(255))) begin
         val_in = {s4_ff.ctl.sign, EXP_MAX, 23'd0};
      end else begin
         val_in = {s4_ff.ctl.sign, exp_f[7:0], sum[22:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (ld[1]) begin
            v_ff[1] <= in_valid;
         end
         for (int k = 2; k <= 5; k++) begin
            if (ld[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         s1_ff <= s1_in;
      end
      if (ld[2]) begin
         s2_ff <= s2_in;
      end
      if (ld[3]) begin
         s3_ff <= s3_in;
      end
      if (ld[4]) begin
         s4_ff <= s4_in;
      end
      if (ld[5]) begin
         val_ff  <= val_in;
         last_ff <= s4_ff.ctl.last;
      end
   end

   assign out_valid = v_ff[5];
   assign out_value = val_ff;
   assign out_last  = last_ff;

endmodule

/* sv/int8_to_float_dequantizer.sv */
`timescale 1ns / 1ps
// Dequantizes one 8-bit sample per transfer to an IEEE single: (sample - zero_point) * scale,
// rounded to nearest even with full IEEE handling of infinities, NaN and subnormals. The
// block takes one sample every clock unless response backpressure stalls it; each request
// transfer passes through the five register stages of the datapath (decode, 8x24 multiply,
// leading-zero count, normalize shift, round), the first of which loads on the transfer
// edge. Backpressure on the response side stalls only the stages that are full. Write
// configuration only while no transfer is in flight.
// Depends on dqz_pkg, dqz_channels and dqz_pipe.
module int8_to_float_dequantizer
   import dqz_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   dqz_req_if.sink               req_if,
   dqz_rsp_if.source             rsp_if,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.signed_mode <= 1'b0;
         cfg_ff.zero_point  <= '0;
         cfg_ff.scale_bits  <= SCALE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_SIGNED_MODE: cfg_ff.signed_mode <= csr_write_data[0];
            CSR_ZERO_POINT:  cfg_ff.zero_point  <= csr_write_data[SAMPLE_W-1:0];
            CSR_SCALE_BITS:  cfg_ff.scale_bits  <= csr_write_data[VALUE_W-1:0];
            default: ;
         endcase
      end
   end

   dqz_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .in_sample (req_if.sample),
      .in_last   (req_if.last_in),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_value (rsp_if.value_bits),
      .out_last  (rsp_if.last_out)
   );

endmodule

/* sv/dqz_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the dequantizer, bound to the top level.
// Depends on dqz_pkg and int8_to_float_dequantizer.
module dqz_checker
   import dqz_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [VALUE_W-1:0] rsp_value_bits
);

   logic [2:0] cnt_ff, cnt_in;
   logic       req_xfer, rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;
   assign cnt_in   = cnt_ff + {2'b00, req_xfer} - {2'b00, rsp_xfer};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value_bits))
      else $error("response changed while stalled");

   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> cnt_ff != 3'd0)
      else $error("response without pending request");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'd5)
      else $error("more transfers in flight than pipeline stages");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without response backpressure");

endmodule

bind int8_to_float_dequantizer dqz_checker u_dqz_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_value_bits (rsp_if.value_bits)
);

/* dv/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench: a scoreboard class predicts each IEEE single product and checks every
// response transfer in order. Plain tasks drive the request channel and the CSR port, a forever
// loop the response stalls. Depends on dqz_pkg, dqz_channels and int8_to_float_dequantizer.
module tb;
   import dqz_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_IDX = 2'd3;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      logic [VALUE_W-1:0] value_bits;
      logic               last_out;
   } dq_result_type;

   class dequant_scoreboard;
      logic               mode_signed;
      logic [7:0]         zp;
      logic [VALUE_W-1:0] scale;
      dq_result_type      pending[$];
      int                 errors;
      int                 checked;

      function new();
         mode_signed = 1'b0;
         zp          = 8'h00;
         scale       = SCALE_RESET;
         errors      = 0;
         checked     = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_SIGNED_MODE: mode_signed = data[0];
            CSR_ZERO_POINT:  zp = data[7:0];
            CSR_SCALE_BITS:  scale = data;
            default: ;
         endcase
      endfunction

      function int byte_val(logic [7:0] raw);
         return mode_signed ? int'($signed(raw)) : int'(raw);
      endfunction

      // exact small-integer times single, round to nearest even
      function logic [31:0] scaled_product(int d, logic [31:0] s);
         logic              sgn;
         int                mag, ee, len, bexp, sh;
         longint unsigned   frac, p, rem, half, sig;
         sgn = (d < 0) ^ s[31];
         mag = (d < 0) ? -d : d;
         if (s[30:23] == EXP_MAX) begin
            if (s[22:0] != 0) return s | QUIET_BIT;
            if (mag == 0) return QNAN_DEFAULT;
            return {sgn, EXP_MAX, 23'd0};
         end
         if (mag == 0 || s[30:0] == 0) return {sgn, 31'd0};
         ee   = (s[30:23] == 0) ? 1 : int'(s[30:23]);
         frac = (s[30:23] == 0) ? {41'd0, s[22:0]} : ({41'd0, s[22:0]} | 64'h80_0000);
         p    = longint'(mag) * frac;
         len  = 0;
         while (len < 40 && (p >> len) != 0) len++;
         bexp = len + ee - 24;
         if (bexp < 1) begin
            sig = p << (ee - 1);
            return {sgn, 8'd0, sig[22:0]};
         end
         if (len > 24) begin
            sh   = len - 24;
            rem  = p & ((64'd1 << sh) - 1);
            half = 64'd1 << (sh - 1);
            sig  = p >> sh;
            if (rem > half || (rem == half && sig[0])) sig++;
            if (sig == (64'd1 << 24)) begin
               sig = sig >> 1;
               bexp++;
            end
         end else begin
            sig = p << (24 - len);
         end
         if (bexp >= 255) return {sgn, EXP_MAX, 23'd0};
         return {sgn, 8'(bexp), sig[22:0]};
      endfunction

      function void note_input(logic [7:0] sample, logic last_in);
         dq_result_type r;
         r.value_bits = scaled_product(byte_val(sample) - byte_val(zp), scale);
         r.last_out   = last_in;
         pending.push_back(r);
      endfunction

      task report(string what);
         $display("MISMATCH @%0t: %s", $realtime, what);
         errors++;
      endtask

      task check_result(logic [VALUE_W-1:0] value_bits, logic last_out);
         dq_result_type r;
         if (pending.size() == 0) begin
            report($sformatf("unexpected transfer value=%h", value_bits));
            return;
         end
         r = pending.pop_front();
         checked++;
         if (value_bits !== r.value_bits)
            report($sformatf("value_bits got %h exp %h", value_bits, r.value_bits));
         if (last_out !== r.last_out)
            report($sformatf("last_out got %b exp %b", last_out, r.last_out));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_SIGNED_MODE;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   dqz_req_if req_ch();
   dqz_rsp_if rsp_ch();

   int8_to_float_dequantizer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_ch),
      .rsp_if           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   dequant_scoreboard sb = new();
   int  send_pct  = 0;
   int  stall_pct = 0;
   bit  hold_req  = 1'b0;
   int  cycles    = 0;
   int  sent      = 0;
   int  cfg_count = 0;

   always #2 clock = ~clock;

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.sample  = '0;
      req_ch.last_in = 1'b0;
      rsp_ch.ready   = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   // response stalls, with an optional long hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (300) @(posedge clock);
         end
         rsp_ch.ready <= (int'($urandom_range(99)) >= stall_pct);
      end
   end

   always @(negedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         sb.note_input(req_ch.sample, req_ch.last_in);
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_result(rsp_ch.value_bits, rsp_ch.last_out);
   end

   task automatic send_item(logic [7:0] sample, logic last_in);
      while (int'($urandom_range(99)) < send_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.sample  <= sample;
      req_ch.last_in <= last_in;
      do @(negedge clock); while (!req_ch.ready);
      @(posedge clock);
      sent++;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.write_reg(idx, data);
      cfg_count++;
      @(posedge clock);
   endtask

   // upper data bits are junk on narrow registers; they must be ignored
   task automatic set_config(logic mode, logic [7:0] zp, logic [31:0] scale);
      drain();
      write_csr(CSR_SIGNED_MODE, {31'($urandom()), mode});
      write_csr(CSR_ZERO_POINT, {16'($urandom_range(16'hFFFF, 0)), 8'h00, zp});
      write_csr(CSR_SCALE_BITS, scale);
   endtask

   function automatic logic [31:0] pick_scale();
      case ($urandom_range(9))
         0: return 32'h7F80_0000 | (32'($urandom_range(1)) << 31);
         1: return 32'h7F80_0000 | 32'($urandom_range(32'h7F_FFFF, 1))
                   | ($urandom() & 32'h8000_0000);
         2: return $urandom() & 32'h807F_FFFF;
         3: return {1'($urandom_range(1)), 8'($urandom_range(254, 240)), 23'($urandom())};
         4: return {1'($urandom_range(1)), 31'd0};
         5: return {1'($urandom_range(1)), 8'($urandom_range(8, 1)), 23'($urandom())};
         6: return 32'h7F7F_FFFF;
         default: return {1'($urandom_range(1)), 8'($urandom_range(140, 110)), 23'($urandom())};
      endcase
   endfunction

   initial begin
      logic [7:0] zp;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset config: unsigned, zero point 0, scale 1.0
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b1);
      send_item(8'h01, 1'b0);
      send_item(8'h80, 1'b0);
      send_item(8'h7F, 1'b1);
      // zero times infinity, and positive infinities
      set_config(1'b1, 8'h80, 32'h7F80_0000);
      send_item(8'h80, 1'b0);
      send_item(8'h7F, 1'b0);
      send_item(8'h00, 1'b1);
      // NaN scale is quieted, payload and sign kept
      set_config(1'b1, 8'h7F, 32'hFF80_0001);
      send_item(8'h12, 1'b0);
      send_item(8'h7F, 1'b1);
      // overflow to infinity
      set_config(1'b0, 8'h00, 32'h7F7F_FFFF);
      send_item(8'hFF, 1'b0);
      send_item(8'h01, 1'b1);
      set_config(1'b0, 8'hFF, 32'hFF7F_FFFF);
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b1);
      // subnormal scale and subnormal results
      set_config(1'b1, 8'h00, 32'h0000_0001);
      send_item(8'h7F, 1'b0);
      send_item(8'h80, 1'b0);
      set_config(1'b0, 8'h10, 32'h0040_0001);
      send_item(8'hFF, 1'b0);
      send_item(8'h10, 1'b1);
      // signed zeros
      set_config(1'b0, 8'h80, 32'h8000_0000);
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b1);
      drain();
      write_csr(CSR_UNUSED_IDX, $urandom());
      send_item(8'h01, 1'b0);

      for (int ph = 0; ph < 8; ph++) begin
         zp = (ph == 1) ? 8'h00 : (ph == 2) ? 8'hFF : 8'($urandom());
         set_config(1'($urandom_range(1)), zp, pick_scale());
         send_pct  = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 36 : 45) : 0;
         stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 3) ? 36 : 45) : 0;
         if (ph == 4) hold_req = 1'b1;
         for (int i = 0; i < 80; i++)
            send_item(8'($urandom()), ($urandom_range(7) == 0));
      end

      drain();
      $display("Checked %0d of %0d transfers over %0d CSR writes, with signed and unsigned modes,",
               sb.checked, sent, cfg_count);
      $display("NaN, infinite, zero, subnormal and overflowing scales and mixed stalls.");
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule

/* int8_to_float_dequantizer.f */
sv/dqz_pkg.sv
sv/dqz_channels.sv
sv/dqz_pipe.sv
sv/int8_to_float_dequantizer.sv
sv/dqz_checker.sv
dv/tb.sv
